@@ sv/euq_pkg.sv @@
package euq_pkg;

	// default build parameters
	localparam int ANGLE_BITS_DEF      = 16;
	localparam int FRACTION_BITS_DEF   = 15;
	localparam int TRIG_ITERATIONS_DEF = 16;

	// CORDIC number formats
	localparam int TRIG_FRAC = 40;          // x, y fraction bits
	localparam int MID_FRAC  = 30;          // rounded cos/sin and pair products
	localparam int XY_W      = 43;          // x, y register width
	localparam int Z_W       = 35;          // angle accumulator, pi = 2^32
	localparam int MID_W     = 32;          // Q1.30 plus headroom
	localparam int PROD_W    = 2 * MID_W;   // full multiplier result
	localparam int SUM_W     = PROD_W + 1;  // sum of two triple products
	localparam int MAX_STEPS = 32;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 43'sd667681663043;

	// lane order inside a CORDIC word
	localparam int LANES      = 3;
	localparam int LANE_YAW   = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_ROLL  = 2;

	// atan(2^-i), full turn = 2^33
	localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STEPS] = '{
		35'h040000000, 35'h025C80A3C, 35'h013F670B6, 35'h00A2223A8,
		35'h005161A86, 35'h0028BAFC2, 35'h00145EC3C, 35'h000A2F8AA,
		35'h000517CA6, 35'h00028BE5E, 35'h000145F30, 35'h0000A2F98,
		35'h0000517CC, 35'h000028BE6, 35'h0000145F4, 35'h00000A2FA,
		35'h00000517C, 35'h0000028BE, 35'h000001460, 35'h000000A30,
		35'h000000518, 35'h00000028C, 35'h000000146, 35'h0000000A2,
		35'h000000052, 35'h000000028, 35'h000000014, 35'h00000000A,
		35'h000000006, 35'h000000002, 35'h000000002, 35'h000000000
	};

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_lane_t;

	typedef cordic_lane_t [LANES-1:0] cordic_word_t;

endpackage

@@ sv/euq_angle_if.sv @@
interface euq_angle_if #(
	parameter int WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] yaw_angle;
	logic signed [WIDTH-1:0] pitch_angle;
	logic signed [WIDTH-1:0] roll_angle;

	modport source (output valid, output yaw_angle, output pitch_angle, output roll_angle,
		input ready);
	modport sink (input valid, input yaw_angle, input pitch_angle, input roll_angle,
		output ready);
endinterface

@@ sv/euq_quat_if.sv @@
interface euq_quat_if #(
	parameter int WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] quat_w;
	logic signed [WIDTH-1:0] quat_x;
	logic signed [WIDTH-1:0] quat_y;
	logic signed [WIDTH-1:0] quat_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
		input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
		output ready);
endinterface

@@ sv/euq_cordic_cell.sv @@
module euq_cordic_cell
	import euq_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  cordic_word_t in_word,
	output logic         out_valid,
	input  logic         out_ready,
	output cordic_word_t out_word
);

	logic         valid_q;
	cordic_word_t word_q;
	cordic_word_t next_word;
	logic         adv;

	// stage moves when empty or when the neighbor takes the word
	assign adv      = !valid_q || out_ready;
	assign in_ready = adv;

	// one rotation step per lane
	always_comb begin
		logic signed [XY_W-1:0] x, y, dx, dy;
		logic signed [Z_W-1:0]  z;
		for (int l = 0; l < LANES; l++) begin
			x  = in_word[l].x;
			y  = in_word[l].y;
			z  = in_word[l].z;
			dx = y >>> STEP;
			dy = x >>> STEP;
			if (!z[Z_W-1]) begin
				next_word[l].x = x - dx;
				next_word[l].y = y + dy;
				next_word[l].z = z - ATAN_TAB[STEP];
			end else begin
				next_word[l].x = x + dx;
				next_word[l].y = y - dy;
				next_word[l].z = z + ATAN_TAB[STEP];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			word_q <= next_word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

@@ sv/euq_quat_math.sv @@
module euq_quat_math
	import euq_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cordic_word_t                   in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [FRACTION_BITS:0]  quat_w,
	output logic signed [FRACTION_BITS:0]  quat_x,
	output logic signed [FRACTION_BITS:0]  quat_y,
	output logic signed [FRACTION_BITS:0]  quat_z
);

	localparam int STAGES   = 6;
	localparam int TRIG_SH  = TRIG_FRAC - MID_FRAC;
	localparam int FINAL_SH = 2 * MID_FRAC - FRACTION_BITS;
	localparam int OUT_W    = FRACTION_BITS + 1;

	localparam logic signed [XY_W-1:0]   XY_HALF   = XY_W'(1) << (TRIG_SH - 1);
	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (MID_FRAC - 1);
	localparam logic signed [SUM_W-1:0]  SUM_HALF  = SUM_W'(1) << (FINAL_SH - 1);

	// per-stage handshake
	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] adv;
	logic [STAGES-1:0] prev_valid;

	assign prev_valid = {valid_q[STAGES-2:0], in_valid};

	always_comb begin
		adv[STAGES-1] = !valid_q[STAGES-1] || out_ready;
		for (int s = STAGES - 2; s >= 0; s--) begin
			adv[s] = !valid_q[s] || adv[s+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int s = 0; s < STAGES; s++) begin
				if (adv[s]) begin
					valid_q[s] <= prev_valid[s];
				end
			end
		end
	end

	// stage 1: round cos/sin of each half angle to Q1.30
	logic signed [MID_W-1:0] cos_s1 [LANES];
	logic signed [MID_W-1:0] sin_s1 [LANES];
	logic signed [MID_W-1:0] cos_rnd [LANES];
	logic signed [MID_W-1:0] sin_rnd [LANES];

	always_comb begin
		logic signed [XY_W-1:0] xs, ys;
		for (int l = 0; l < LANES; l++) begin
			xs = (in_word[l].x + XY_HALF) >>> TRIG_SH;
			ys = (in_word[l].y + XY_HALF) >>> TRIG_SH;
			cos_rnd[l] = xs[MID_W-1:0];
			sin_rnd[l] = ys[MID_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && prev_valid[0]) begin
			cos_s1 <= cos_rnd;
			sin_s1 <= sin_rnd;
		end
	end

	// stage 2: yaw-pitch pair products
	logic signed [PROD_W-1:0] cycp_s2, sysp_s2, sycp_s2, cysp_s2;
	logic signed [MID_W-1:0]  cr_s2, sr_s2;

	always_ff @(posedge clk) begin
		if (adv[1] && prev_valid[1]) begin
			cycp_s2 <= cos_s1[LANE_YAW] * cos_s1[LANE_PITCH];
			sysp_s2 <= sin_s1[LANE_YAW] * sin_s1[LANE_PITCH];
			sycp_s2 <= sin_s1[LANE_YAW] * cos_s1[LANE_PITCH];
			cysp_s2 <= cos_s1[LANE_YAW] * sin_s1[LANE_PITCH];
			cr_s2   <= cos_s1[LANE_ROLL];
			sr_s2   <= sin_s1[LANE_ROLL];
		end
	end

	// stage 3: round pair products back to Q1.30
	logic signed [MID_W-1:0]  cycp_s3, sysp_s3, sycp_s3, cysp_s3;
	logic signed [MID_W-1:0]  cr_s3, sr_s3;
	logic signed [PROD_W-1:0] cycp_r, sysp_r, sycp_r, cysp_r;

	assign cycp_r = (cycp_s2 + PROD_HALF) >>> MID_FRAC;
	assign sysp_r = (sysp_s2 + PROD_HALF) >>> MID_FRAC;
	assign sycp_r = (sycp_s2 + PROD_HALF) >>> MID_FRAC;
	assign cysp_r = (cysp_s2 + PROD_HALF) >>> MID_FRAC;

	always_ff @(posedge clk) begin
		if (adv[2] && prev_valid[2]) begin
			cycp_s3 <= cycp_r[MID_W-1:0];
			sysp_s3 <= sysp_r[MID_W-1:0];
			sycp_s3 <= sycp_r[MID_W-1:0];
			cysp_s3 <= cysp_r[MID_W-1:0];
			cr_s3   <= cr_s2;
			sr_s3   <= sr_s2;
		end
	end

	// stage 4: triple products, 60 fraction bits
	logic signed [PROD_W-1:0] t_cycp_cr_s4, t_sysp_sr_s4, t_cycp_sr_s4, t_sysp_cr_s4;
	logic signed [PROD_W-1:0] t_sycp_sr_s4, t_cysp_cr_s4, t_sycp_cr_s4, t_cysp_sr_s4;

	always_ff @(posedge clk) begin
		if (adv[3] && prev_valid[3]) begin
			t_cycp_cr_s4 <= cycp_s3 * cr_s3;
			t_sysp_sr_s4 <= sysp_s3 * sr_s3;
			t_cycp_sr_s4 <= cycp_s3 * sr_s3;
			t_sysp_cr_s4 <= sysp_s3 * cr_s3;
			t_sycp_sr_s4 <= sycp_s3 * sr_s3;
			t_cysp_cr_s4 <= cysp_s3 * cr_s3;
			t_sycp_cr_s4 <= sycp_s3 * cr_s3;
			t_cysp_sr_s4 <= cysp_s3 * sr_s3;
		end
	end

	// stage 5: component sums
	logic signed [SUM_W-1:0] sum_s5 [4];

	always_ff @(posedge clk) begin
		if (adv[4] && prev_valid[4]) begin
			sum_s5[0] <= SUM_W'(t_cycp_cr_s4) + SUM_W'(t_sysp_sr_s4);
			sum_s5[1] <= SUM_W'(t_cycp_sr_s4) - SUM_W'(t_sysp_cr_s4);
			sum_s5[2] <= SUM_W'(t_sycp_sr_s4) + SUM_W'(t_cysp_cr_s4);
			sum_s5[3] <= SUM_W'(t_sycp_cr_s4) - SUM_W'(t_cysp_sr_s4);
		end
	end

	// stage 6: round to Q1.F and saturate, output register
	logic signed [OUT_W-1:0] quat_s6 [4];
	logic signed [OUT_W-1:0] quat_sat [4];

	always_comb begin
		logic signed [SUM_W-1:0] r;
		for (int c = 0; c < 4; c++) begin
			r = (sum_s5[c] + SUM_HALF) >>> FINAL_SH;
			// in range when all bits above the fraction match the sign
			if (r[SUM_W-1:FRACTION_BITS] == '0 || r[SUM_W-1:FRACTION_BITS] == '1) begin
				quat_sat[c] = r[OUT_W-1:0];
			end else begin
				quat_sat[c] = {r[SUM_W-1], {FRACTION_BITS{~r[SUM_W-1]}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5] && prev_valid[5]) begin
			quat_s6 <= quat_sat;
		end
	end

	assign quat_w = quat_s6[0];
	assign quat_x = quat_s6[1];
	assign quat_y = quat_s6[2];
	assign quat_z = quat_s6[3];

endmodule

@@ sv/euler_to_quaternion_unit.sv @@
// Channel   Direction  Word
// angles    in         yaw_angle, pitch_angle, roll_angle (ANGLE_BITS, pi = 2^(ANGLE_BITS-1))
// quat      out        quat_w, quat_x, quat_y, quat_z (Q1.FRACTION_BITS, saturated)
//
// Takes one angle word per clock and returns one quaternion word per clock while the quat output is not stalled.
// The pipeline is one CORDIC cell per rotation step
// (all three half angles side by side), then six rounding/multiply stages.
// Reset clears only the stage valid flags.
// Ready ripples back stage by stage from the output register, so a stalled
// output holds only the full stages; bubbles ahead of it still take words.
module euler_to_quaternion_unit
	import euq_pkg::*;
#(
	parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
	parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
	parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	euq_angle_if.sink   angles,
	euq_quat_if.source  quat
);

	localparam int ANGLE_SH = 32 - ANGLE_BITS;

	cordic_word_t chain_word  [TRIG_ITERATIONS+1];
	logic         chain_valid [TRIG_ITERATIONS+1];
	logic         chain_ready [TRIG_ITERATIONS+1];

	// half angle into the z accumulator, gain into x
	function automatic cordic_lane_t lane_init(input logic [ANGLE_BITS-1:0] a);
		cordic_lane_t ln;
		ln.x = CORDIC_GAIN;
		ln.y = '0;
		ln.z = {{(Z_W-ANGLE_BITS){a[ANGLE_BITS-1]}}, a} << ANGLE_SH;
		return ln;
	endfunction

	assign chain_word[0][LANE_YAW]   = lane_init(angles.yaw_angle);
	assign chain_word[0][LANE_PITCH] = lane_init(angles.pitch_angle);
	assign chain_word[0][LANE_ROLL]  = lane_init(angles.roll_angle);

	assign chain_valid[0] = angles.valid;
	assign angles.ready   = chain_ready[0];

	// row of rotation cells
	for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_cell
		euq_cordic_cell #(
			.STEP (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_word   (chain_word[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_word  (chain_word[g+1])
		);
	end

	// quaternion products and output register
	euq_quat_math #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_math (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[TRIG_ITERATIONS]),
		.in_ready  (chain_ready[TRIG_ITERATIONS]),
		.in_word   (chain_word[TRIG_ITERATIONS]),
		.out_valid (quat.valid),
		.out_ready (quat.ready),
		.quat_w    (quat.quat_w),
		.quat_x    (quat.quat_x),
		.quat_y    (quat.quat_y),
		.quat_z    (quat.quat_z)
	);

endmodule
